/* rtl/gbhc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the ground bin height classifier.
// No dependencies; imported by every module of the block.
package gbhc_pkg;

	// Q0.16 Gaussian weights, sigma 1
	localparam logic [15:0] W_SIDE   = 16'd17961;
	localparam logic [15:0] W_CENTER = 16'd29613;
	localparam int          Q_FRAC   = 16;

	// register reset values, millimeters
	localparam int RST_LOW_LIMIT  = -2000;
	localparam int RST_HIGH_LIMIT = -1400;
	localparam int RST_STEP_LIMIT = 400;
	localparam int RST_SENSOR     = 1700;

	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_LOW_LIMIT  = 2'd0,
		REG_HIGH_LIMIT = 2'd1,
		REG_STEP_LIMIT = 2'd2,
		REG_SENSOR     = 2'd3
	} cfg_reg_t;

	// what the back end does with one queued window
	typedef enum logic [1:0] {
		CMD_SINGLE  = 2'd0,  // one-bin segment: one result, no neighbors
		CMD_MID     = 2'd1,  // result for the pending bin
		CMD_MID_END = 2'd2   // pending bin, then the last bin of the segment
	} cmd_kind_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* rtl/gbhc_front.sv */
`timescale 1ns / 1ps
// Front end: accepts bins, clamps heights, tracks the segment window and
// queues one command per window. Depends on gbhc_pkg.
module gbhc_front import gbhc_pkg::*; #(
	parameter int HEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic signed [HEIGHT_BITS-1:0] min_height,
	input  logic                          segment_end,
	input  logic signed [HEIGHT_BITS-1:0] low_limit,
	input  logic signed [HEIGHT_BITS-1:0] high_limit,
	input  logic signed [HEIGHT_BITS-1:0] sensor_level,
	input  q_stat_t                       q_stat,
	output logic                          push,
	output logic [3*HEIGHT_BITS+2:0]      cmd
);

	typedef enum logic [1:0] {
		SEEN_NONE = 2'd0,
		SEEN_ONE  = 2'd1,
		SEEN_TWO  = 2'd2
	} seen_t;

	seen_t                         seen_q;
	logic signed [HEIGHT_BITS-1:0] older_q;
	logic signed [HEIGHT_BITS-1:0] pend_q;
	logic signed [HEIGHT_BITS-1:0] h;
	logic                          accept;
	cmd_kind_t                     kind;

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		priority if (min_height > low_limit && min_height < high_limit) begin
			h = min_height;
		end else if (min_height >= high_limit) begin
			h = sensor_level;
		end else begin
			h = low_limit;
		end
	end

	always_comb begin
		if (seen_q == SEEN_NONE) begin
			kind = CMD_SINGLE;
		end else if (segment_end) begin
			kind = CMD_MID_END;
		end else begin
			kind = CMD_MID;
		end
	end

	assign push = accept && (seen_q != SEEN_NONE || segment_end);
	assign cmd  = {kind, (seen_q == SEEN_TWO), older_q, pend_q, h};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= SEEN_NONE;
			older_q <= '0;
			pend_q  <= '0;
		end else if (accept) begin
			if (segment_end) begin
				seen_q  <= SEEN_NONE;
				older_q <= '0;
				pend_q  <= '0;
			end else begin
				seen_q  <= (seen_q == SEEN_NONE) ? SEEN_ONE : SEEN_TWO;
				older_q <= pend_q;
				pend_q  <= h;
			end
		end
	end

endmodule

/* rtl/gbhc_fifo.sv */
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Depends on gbhc_pkg for the status struct.
module gbhc_fifo import gbhc_pkg::*; #(
	parameter int WIDTH = 51,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output q_stat_t          stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/gbhc_back.sv */
`timescale 1ns / 1ps
// Back end: expands queued windows into results, smooths, takes the step and
// classifies in three stages ending in the output register. Depends on gbhc_pkg.
module gbhc_back import gbhc_pkg::*; #(
	parameter int HEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [3*HEIGHT_BITS+2:0]      cmd,
	input  q_stat_t                       q_stat,
	output logic                          pop,
	input  logic signed [HEIGHT_BITS-1:0] high_limit,
	input  logic signed [HEIGHT_BITS:0]   step_limit,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic signed [HEIGHT_BITS-1:0] clamped_height,
	output logic signed [HEIGHT_BITS-1:0] smoothed_height,
	output logic signed [HEIGHT_BITS:0]   height_step,
	output logic                          is_ground,
	output logic                          last_of_segment
);

	localparam int HB = HEIGHT_BITS;
	localparam int SB = HEIGHT_BITS + 1;
	localparam int PW = HEIGHT_BITS + 17;
	localparam int AW = PW + 2;
	localparam logic signed [16:0]   WS = $signed({1'b0, W_SIDE});
	localparam logic signed [16:0]   WC = $signed({1'b0, W_CENTER});
	localparam logic signed [AW-1:0] HALF = AW'(1) <<< (Q_FRAC - 1);

	// queued window
	cmd_kind_t         kind;
	logic              has_older;
	logic signed [HB-1:0] older, pend, cur;

	assign kind      = cmd_kind_t'(cmd[3*HB+2:3*HB+1]);
	assign has_older = cmd[3*HB];
	assign older     = cmd[3*HB-1:2*HB];
	assign pend      = cmd[2*HB-1:HB];
	assign cur       = cmd[HB-1:0];

	logic sub_q;  // second result of a segment-end window
	logic en1, en2, en3;

	logic signed [HB-1:0] ctr_d, prv_d, nxt_d;
	logic                 hp_d, hn_d, last_d;

	logic                 v1_s1;
	logic signed [PW-1:0] pc_s1, pp_s1, pn_s1;
	logic signed [HB-1:0] ctr_s1, prv_s1, nxt_s1;
	logic                 hp_s1, hn_s1, last_s1;

	logic                 v2_s2;
	logic signed [HB-1:0] ctr_s2, sm_s2;
	logic signed [SB-1:0] step_s2;
	logic                 last_s2;

	logic signed [AW-1:0] acc;
	logic signed [SB-1:0] diff_b, diff_f, step_d;

	assign en3 = !m_tvalid || m_tready;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign pop = !q_stat.empty && en1 && (kind != CMD_MID_END || sub_q);

	always_comb begin
		ctr_d  = cur;
		prv_d  = '0;
		nxt_d  = '0;
		hp_d   = 1'b0;
		hn_d   = 1'b0;
		last_d = 1'b1;
		unique case (kind)
			CMD_MID: begin
				ctr_d  = pend;
				prv_d  = older;
				nxt_d  = cur;
				hp_d   = has_older;
				hn_d   = 1'b1;
				last_d = 1'b0;
			end
			CMD_MID_END: begin
				if (!sub_q) begin
					ctr_d  = pend;
					prv_d  = older;
					nxt_d  = cur;
					hp_d   = has_older;
					hn_d   = 1'b1;
					last_d = 1'b0;
				end else begin
					ctr_d = cur;
					prv_d = pend;
					hp_d  = 1'b1;
				end
			end
			default: begin
				ctr_d = cur;
			end
		endcase
	end

	// stage 1: weight products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			sub_q <= 1'b0;
		end else if (en1) begin
			v1_s1 <= !q_stat.empty;
			if (!q_stat.empty && kind == CMD_MID_END) begin
				sub_q <= !sub_q;
			end
		end
	end

	// signed zero keeps the products signed
	always_ff @(posedge clk) begin
		if (en1) begin
			pc_s1   <= ctr_d * WC;
			pp_s1   <= hp_d ? prv_d * WS : PW'(0);
			pn_s1   <= hn_d ? nxt_d * WS : PW'(0);
			ctr_s1  <= ctr_d;
			prv_s1  <= prv_d;
			nxt_s1  <= nxt_d;
			hp_s1   <= hp_d;
			hn_s1   <= hn_d;
			last_s1 <= last_d;
		end
	end

	// stage 2: sum, round half up, neighbor step
	always_comb begin
		acc    = AW'(pc_s1) + AW'(pp_s1) + AW'(pn_s1) + HALF;
		diff_b = SB'(ctr_s1) - SB'(prv_s1);
		diff_f = SB'(ctr_s1) - SB'(nxt_s1);
		if (hp_s1 && hn_s1) begin
			step_d = (diff_b > diff_f) ? diff_b : diff_f;
		end else if (hp_s1) begin
			step_d = diff_b;
		end else if (hn_s1) begin
			step_d = diff_f;
		end else begin
			step_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			ctr_s2  <= ctr_s1;
			sm_s2   <= acc[Q_FRAC+HB-1:Q_FRAC];
			step_s2 <= step_d;
			last_s2 <= last_s1;
		end
	end

	// stage 3: classification into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en3) begin
			m_tvalid <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			clamped_height  <= ctr_s2;
			smoothed_height <= sm_s2;
			height_step     <= step_s2;
			is_ground       <= (step_s2 < step_limit) &&
			                   (sm_s2 < high_limit || ctr_s2 < high_limit);
			last_of_segment <= last_s2;
		end
	end

endmodule

/* rtl/ground_bin_height_classifier.sv */
`timescale 1ns / 1ps
// Ground bin height classifier: one item per clock in, one result per clock
// out while the output is not held off. A bin's window is queued once the
// following bin of its segment is taken; a segment's last bin releases the
// pending result, if any, then its own. Since the first bin of a segment
// queues nothing the three-stage back end keeps pace with one item per clock.
// A four-entry command queue sits between the input front end and the back
// end, so s_tready drops only once the output has been held off long enough
// to fill it. Configuration is taken in any cycle (cfg_ready is always high)
// and must only change while the block is idle. Depends on gbhc_pkg,
// gbhc_front, gbhc_fifo and gbhc_back.
module ground_bin_height_classifier import gbhc_pkg::*; #(
	parameter int HEIGHT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave: [HEIGHT_BITS-1:0] min_height
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((HEIGHT_BITS+7)/8)*8-1:0]     s_tdata,
	input  logic                                 s_tlast,      // segment_end
	// master: clamped_height, smoothed_height, height_step (low to high)
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((3*HEIGHT_BITS+8)/8)*8-1:0]   m_tdata,
	output logic                                 m_tuser,      // is_ground
	output logic                                 m_tlast,      // last_of_segment
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]              cfg_index,
	input  logic [HEIGHT_BITS:0]                 cfg_data
);

	localparam int HB     = HEIGHT_BITS;
	localparam int CMD_W  = 3 * HEIGHT_BITS + 3;
	localparam int OUT_TW = ((3 * HEIGHT_BITS + 8) / 8) * 8;

	logic signed [HB-1:0] low_q, high_q, sensor_q;
	logic signed [HB:0]   step_lim_q;

	q_stat_t              q_stat;
	logic                 push, pop;
	logic [CMD_W-1:0]     cmd_in, cmd_out;

	logic signed [HB-1:0] clamped, smoothed;
	logic signed [HB:0]   step;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q      <= HB'(RST_LOW_LIMIT);
			high_q     <= HB'(RST_HIGH_LIMIT);
			step_lim_q <= (HB + 1)'(RST_STEP_LIMIT);
			sensor_q   <= HB'(RST_SENSOR);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOW_LIMIT:  low_q      <= cfg_data[HB-1:0];
				REG_HIGH_LIMIT: high_q     <= cfg_data[HB-1:0];
				REG_STEP_LIMIT: step_lim_q <= cfg_data;
				REG_SENSOR:     sensor_q   <= cfg_data[HB-1:0];
			endcase
		end
	end

	gbhc_front #(.HEIGHT_BITS(HB)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.min_height    (s_tdata[HB-1:0]),
		.segment_end   (s_tlast),
		.low_limit     (low_q),
		.high_limit    (high_q),
		.sensor_level  (sensor_q),
		.q_stat        (q_stat),
		.push          (push),
		.cmd           (cmd_in)
	);

	gbhc_fifo #(.WIDTH(CMD_W), .DEPTH(4)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.pop    (pop),
		.rdata  (cmd_out),
		.stat   (q_stat)
	);

	gbhc_back #(.HEIGHT_BITS(HB)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd_out),
		.q_stat          (q_stat),
		.pop             (pop),
		.high_limit      (high_q),
		.step_limit      (step_lim_q),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.clamped_height  (clamped),
		.smoothed_height (smoothed),
		.height_step     (step),
		.is_ground       (m_tuser),
		.last_of_segment (m_tlast)
	);

	assign m_tdata = OUT_TW'({step, smoothed, clamped});

endmodule

/* rtl/gbhc_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the ground bin height classifier, bound to the top.
// Depends on gbhc_pkg and ground_bin_height_classifier.
module gbhc_checker import gbhc_pkg::*; #(
	parameter int HEIGHT_BITS = 16
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [((3*HEIGHT_BITS+8)/8)*8-1:0] m_tdata,
	input logic                               m_tuser,
	input logic                               m_tlast,
	input logic                               cfg_ready
);

	// a held-off result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
		$stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

	// a full queue sits behind a full back end
	a_full_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	a_handshake_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_tready, m_tvalid}))
		else $error("handshake signal unknown");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind ground_bin_height_classifier gbhc_checker #(.HEIGHT_BITS(HEIGHT_BITS)) u_gbhc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser),
	.m_tlast   (m_tlast),
	.cfg_ready (cfg_ready)
);

/* tb/sv/ground_bin_height_classifier_tb.sv */
`timescale 1ns / 1ps
// Testbench for ground_bin_height_classifier: streams lidar segments under changing
// limits, predicts each bin's clamp, smoothing, step and ground flag, checks results in order.
// Depends on gbhc_pkg and the block's RTL.
module ground_bin_height_classifier_tb;
	import gbhc_pkg::*;

	localparam int HB          = 16;
	localparam int SETTLE      = 24;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic signed [HB-1:0] clamped;
		logic signed [HB-1:0] smoothed;
		logic signed [HB:0]   step;
		logic                 ground;
		logic                 last;
	} bin_grade_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	wire         s_tready;
	logic [15:0] s_tdata   = '0;  // min_height
	logic        s_tlast   = 1'b0;
	wire         m_tvalid;
	logic        m_tready  = 1'b0;
	wire  [55:0] m_tdata;         // clamped_height, smoothed_height, height_step
	wire         m_tuser;         // is_ground
	wire         m_tlast;
	logic        cfg_valid = 1'b0;
	wire         cfg_ready;
	cfg_reg_t    cfg_index = REG_LOW_LIMIT;
	logic [16:0] cfg_data  = '0;

	// predictor copy of the registers and the bin window
	logic signed [HB-1:0] low_lim   = HB'(RST_LOW_LIMIT);
	logic signed [HB-1:0] high_lim  = HB'(RST_HIGH_LIMIT);
	logic signed [HB:0]   step_lim  = (HB + 1)'(RST_STEP_LIMIT);
	logic signed [HB-1:0] sensor_ht = HB'(RST_SENSOR);
	logic signed [HB-1:0] prior_bin = '0;
	logic signed [HB-1:0] held_bin  = '0;
	logic [1:0]           bins_held = '0;

	bin_grade_t bin_grades[$];
	int  mismatches  = 0;
	int  idle_cycles = 0;
	int  items_sent  = 0;
	int  hold_len    = 0;
	bit  steady      = 1'b0;

	ground_bin_height_classifier #(.HEIGHT_BITS(HB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic bin_grade_t grade_bin(bit has_prev, logic signed [HB-1:0] prev,
			logic signed [HB-1:0] cur, bit has_next, logic signed [HB-1:0] nxt, bit last);
		longint acc, sm, stp, back, fwd;
		bin_grade_t g;
		acc = longint'(W_CENTER) * longint'(cur);
		if (has_prev)
			acc += longint'(W_SIDE) * longint'(prev);
		if (has_next)
			acc += longint'(W_SIDE) * longint'(nxt);
		// round half up == floor of (acc + half)
		sm   = (acc + 32768) >>> Q_FRAC;
		back = longint'(cur) - longint'(prev);
		fwd  = longint'(cur) - longint'(nxt);
		if (has_prev && has_next)
			stp = (back > fwd) ? back : fwd;
		else if (has_prev)
			stp = back;
		else if (has_next)
			stp = fwd;
		else
			stp = 0;
		g.clamped  = cur;
		g.smoothed = sm[HB-1:0];
		g.step     = stp[HB:0];
		g.ground   = (stp < longint'(step_lim)) &&
			(sm < longint'(high_lim) || cur < high_lim);
		g.last     = last;
		return g;
	endfunction

	function automatic void queue_grade(bin_grade_t g);
		bin_grades = {bin_grades, g};
	endfunction

	function automatic void classify_bin(logic signed [HB-1:0] raw, bit seg_end);
		logic signed [HB-1:0] h;
		if (raw > low_lim && raw < high_lim)
			h = raw;
		else if (raw >= high_lim)
			h = sensor_ht;
		else
			h = low_lim;
		if (bins_held == 0) begin
			if (seg_end) begin
				queue_grade(grade_bin(1'b0, '0, h, 1'b0, '0, 1'b1));
			end else begin
				held_bin  = h;
				bins_held = 2'd1;
			end
		end else begin
			queue_grade(grade_bin(bins_held >= 2, prior_bin, held_bin, 1'b1, h, 1'b0));
			if (seg_end) begin
				queue_grade(grade_bin(1'b1, held_bin, h, 1'b0, '0, 1'b1));
				prior_bin = '0;
				held_bin  = '0;
				bins_held = 2'd0;
			end else begin
				prior_bin = held_bin;
				held_bin  = h;
				bins_held = 2'd2;
			end
		end
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 70);
	endfunction

	function automatic logic signed [HB-1:0] pick_height();
		int r, v;
		r = $urandom_range(0, 99);
		if (r < 25)
			v = int'($urandom_range(0, 65535)) - 32768;
		else if (r < 30)
			v = ($urandom_range(0, 1)) ? int'(high_lim) : int'(low_lim);
		else if (r < 45)
			v = int'(low_lim) + int'($urandom_range(0, 600)) - 300;
		else
			v = int'(high_lim) + int'($urandom_range(0, 1600)) - 800;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[HB-1:0];
	endfunction

	function automatic int seg_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 1;
		if (r < 85)
			return $urandom_range(2, 10);
		return $urandom_range(11, 40);
	endfunction

	task automatic send_bin(input int h, input bit seg_end);
		int gap;
		gap = steady ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= h[HB-1:0];
		s_tlast  <= seg_end;
		do @(posedge clk); while (!s_tready);
		classify_bin(h[HB-1:0], seg_end);
		items_sent++;
	endtask

	task automatic send_segment(input int len);
		for (int i = 0; i < len; i++)
			send_bin(pick_height(), i == len - 1);
	endtask

	// every phase ends on a segment end, so an empty queue means an idle block
	task automatic settle();
		s_tvalid <= 1'b0;
		while (bin_grades.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [HB:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LOW_LIMIT:  low_lim   = d[HB-1:0];
			REG_HIGH_LIMIT: high_lim  = d[HB-1:0];
			REG_STEP_LIMIT: step_lim  = d;
			REG_SENSOR:     sensor_ht = d[HB-1:0];
			default: ;
		endcase
	endtask

	task automatic write_limits(input int lo, input int hi, input int st, input int sen);
		settle();
		write_reg(REG_LOW_LIMIT, lo[HB:0]);
		write_reg(REG_HIGH_LIMIT, hi[HB:0]);
		write_reg(REG_STEP_LIMIT, st[HB:0]);
		write_reg(REG_SENSOR, sen[HB:0]);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_typical_limits();
		int lo;
		lo = -2500 + int'($urandom_range(0, 1000));
		write_limits(lo, lo + int'($urandom_range(100, 1500)), $urandom_range(0, 900),
			$urandom_range(0, 3000));
	endtask

	// reset limits: values on and next to both limits, one-, two- and four-bin segments
	task automatic test_reset_limits();
		send_bin(-2000, 1'b0);
		send_bin(-1999, 1'b0);
		send_bin(-1401, 1'b0);
		send_bin(-1400, 1'b1);
		send_bin(-1401, 1'b1);
		send_bin(-32768, 1'b0);
		send_bin(32767, 1'b1);
	endtask

	task automatic test_open_limits();
		write_limits(-32768, 32767, 65535, -32768);
		send_bin(32767, 1'b0);
		send_bin(-32768, 1'b0);
		send_bin(32766, 1'b0);
		send_bin(-32767, 1'b1);
		send_bin(-32768, 1'b1);
		send_bin(16'sh5555, 1'b0);
		send_bin(16'shAAAA, 1'b1);
	endtask

	// low above high: the upper test wins for big values, the rest go low
	task automatic test_crossed_limits();
		write_limits(1000, -1000, -65535, 32767);
		send_bin(0, 1'b0);
		send_bin(1000, 1'b0);
		send_bin(-1000, 1'b0);
		send_bin(5000, 1'b1);
		send_bin(-32768, 1'b1);
	endtask

	task automatic test_random_phases();
		int start;
		for (int phase = 0; phase < 5; phase++) begin
			if (phase % 2 == 1)
				write_limits($urandom_range(0, 17'h1ffff), $urandom_range(0, 17'h1ffff),
					$urandom_range(0, 17'h1ffff), $urandom_range(0, 17'h1ffff));
			else
				write_typical_limits();
			steady = (phase == 2);
			start  = items_sent;
			while (items_sent - start < 100)
				send_segment(seg_len());
			steady = 1'b0;
		end
	endtask

	// receiver holds off long enough for the block to back up into its input
	task automatic test_input_stall();
		int start;
		write_typical_limits();
		steady   = 1'b1;
		hold_len = 300;
		start    = items_sent;
		while (items_sent - start < 60)
			send_segment(seg_len());
		while (hold_len != 0) @(posedge clk);
		steady = 1'b0;
	endtask

	task automatic test_steady_burst();
		int start;
		write_limits(-2000, -1400, 400, 1700);
		steady = 1'b1;
		start  = items_sent;
		while (items_sent - start < 40)
			send_segment(seg_len());
		steady = 1'b0;
	endtask

	initial begin : sink
		int stall;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				m_tready <= 1'b1;
			end else if (!steady && $urandom_range(0, 99) < 30) begin
				m_tready <= 1'b0;
				stall = gap_len() + 1;
				repeat (stall) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		bin_grade_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[48:32], m_tuser, m_tlast};
			if (bin_grades.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none outstanding: %p", $realtime, got);
			end else begin
				want = bin_grades.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: mismatch exp clamp %0d smooth %0d step %0d ",
							"gnd %0b last %0b | got clamp %0d smooth %0d step %0d ",
							"gnd %0b last %0b"},
							$realtime, want.clamped, want.smoothed, want.step, want.ground,
							want.last, got.clamped, got.smoothed, got.step, got.ground,
							got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_limits();
		test_open_limits();
		test_crossed_limits();
		test_random_phases();
		test_input_stall();
		test_steady_burst();
		settle();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
